// File: rtl/dqp_pkg.sv
// Package for the deque with parity partition: widths, command and status codes,
// back-end states and the result word structure. It depends on nothing else.
package dqp_pkg;

    // Default sizes of the ring store.
    localparam int DEPTH_DEF     = 16;
    localparam int WORD_BITS_DEF = 32;

    // Fixed widths of the channel fields.
    localparam int WORD_W   = 32;
    localparam int ACT_W    = 3;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    // Command queue between the front and the back.
    localparam int CQ_DEPTH = 2;
    localparam int CQ_AW    = $clog2(CQ_DEPTH);
    localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);

    // Result queue at the output.
    localparam int RQ_DEPTH = 2;
    localparam int RQ_AW    = $clog2(RQ_DEPTH);
    localparam int RQ_CW    = $clog2(RQ_DEPTH + 1);

    // Action codes as they arrive on the input channel.
    localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_POP_BACK   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_PARTITION  = 3'd4;
    localparam logic [ACT_W-1:0] ACT_READ_OUT   = 3'd5;

    // Classified commands handed from the front to the back.
    typedef enum logic [2:0] {
        CMD_PUSH_FRONT,
        CMD_PUSH_BACK,
        CMD_POP_FRONT,
        CMD_POP_BACK,
        CMD_PARTITION,
        CMD_READ_OUT,
        CMD_NOP
    } t_cmd;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Back-end sequencer states.
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_PART,
        BK_PDRAIN
    } t_bk_state;

    // One result word as it travels from the back to the result queue.
    typedef struct packed {
        logic signed [WORD_W-1:0] word;
        t_status                  status;
        logic [OCC_W-1:0]         occupancy;
        logic                     last;
    } t_res;

endpackage

// File: rtl/dqp_if.sv
// Channel interfaces of the deque with parity partition: command input and result output.
// Depends on dqp_pkg for the field widths.
interface dqp_in_if;
    import dqp_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [ACT_W-1:0]         action;
    logic signed [WORD_W-1:0] value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

interface dqp_out_if;
    import dqp_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] word;
    logic [STATUS_W-1:0]      status;
    logic [OCC_W-1:0]         occupancy;
    logic                     last;

    modport source (output valid, output word, output status, output occupancy, output last,
                    input ready);
    modport sink   (input valid, input word, input status, input occupancy, input last,
                    output ready);
endinterface

// File: rtl/dqp_front.sv
// Front end of the deque: accepts input words, classifies the action code and
// buffers commands in a short queue. Depends on dqp_pkg and dqp_in_if.
module dqp_front #(
    parameter int WORD_BITS = dqp_pkg::WORD_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    dqp_in_if.sink               i_in,
    output logic                 o_cmd_valid,
    input  logic                 i_cmd_ready,
    output dqp_pkg::t_cmd        o_cmd,
    output logic [WORD_BITS-1:0] o_cmd_value
);
    import dqp_pkg::*;

    logic [CQ_CW-1:0]     r_cnt, n_cnt;
    logic [CQ_AW-1:0]     r_wp, r_rp;
    t_cmd                 r_q_cmd [CQ_DEPTH];
    logic [WORD_BITS-1:0] r_q_val [CQ_DEPTH];
    t_cmd                 cls_cmd;
    logic [WORD_BITS-1:0] cls_value;
    logic                 push, pop;

    // Decode the action code into a command; unused codes become a no-op.
    always_comb begin
        unique case (i_in.action)
            ACT_PUSH_FRONT: cls_cmd = CMD_PUSH_FRONT;
            ACT_PUSH_BACK:  cls_cmd = CMD_PUSH_BACK;
            ACT_POP_FRONT:  cls_cmd = CMD_POP_FRONT;
            ACT_POP_BACK:   cls_cmd = CMD_POP_BACK;
            ACT_PARTITION:  cls_cmd = CMD_PARTITION;
            ACT_READ_OUT:   cls_cmd = CMD_READ_OUT;
            default:        cls_cmd = CMD_NOP;
        endcase
    end

    // A pushed value keeps only the low bits that fit a store entry, or is zero-extended to a wider entry.
    if (WORD_BITS <= WORD_W) begin : g_val_trunc
        assign cls_value = i_in.value[WORD_BITS-1:0];
    end else begin : g_val_ext
        assign cls_value = {{(WORD_BITS - WORD_W){1'b0}}, i_in.value};
    end

    // Queue handshakes.
    assign i_in.ready  = (r_cnt != CQ_CW'(CQ_DEPTH));
    assign push        = i_in.valid && i_in.ready;
    assign o_cmd_valid = (r_cnt != '0);
    assign pop         = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_q_cmd[r_rp];
    assign o_cmd_value = r_q_val[r_rp];

    // Next fill level.
    always_comb begin
        case ({push, pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    // Queue pointers and level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wp  <= '0;
            r_rp  <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    // Queue payload.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_cmd[r_wp] <= cls_cmd;
            r_q_val[r_wp] <= cls_value;
        end
    end

endmodule

// File: rtl/dqp_back.sv
// Back end of the deque: ring store in a two-bank memory, pointers, and the
// sequencer for pops, pushes, read out and the stable partition. Depends on dqp_pkg.
module dqp_back #(
    parameter int DEPTH     = dqp_pkg::DEPTH_DEF,
    parameter int WORD_BITS = dqp_pkg::WORD_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cmd_valid,
    output logic                      o_cmd_ready,
    input  dqp_pkg::t_cmd             i_cmd,
    input  logic [WORD_BITS-1:0]      i_cmd_value,
    input  logic [dqp_pkg::RQ_CW-1:0] i_level,
    output logic                      o_res_push,
    output dqp_pkg::t_res             o_res
);
    import dqp_pkg::*;

    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int MEM_N = 2 ** (AW + 1);

    // Ring position of an entry at a given offset from the front.
    function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [AW:0] sum;
        sum = {1'b0, base} + (AW + 1)'(off);
        if (sum >= (AW + 1)'(DEPTH)) begin
            sum = sum - (AW + 1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    t_bk_state            r_state, n_state;
    logic [AW-1:0]        r_front, n_front;
    logic [CW-1:0]        r_count, n_count;
    logic                 r_bank, n_bank;
    logic [CW-1:0]        r_idx, n_idx;
    logic                 r_pass, n_pass;
    logic [CW-1:0]        r_n, n_n;

    logic [WORD_BITS-1:0] r_mem [MEM_N];
    logic [WORD_BITS-1:0] r_rdata;
    logic                 mem_we;
    logic [AW:0]          mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic [AW:0]          mem_raddr;

    logic                 r_rs_vld, n_rs_vld;
    logic                 r_rs_use_mem, n_rs_use_mem;
    t_status              r_rs_status, n_rs_status;
    logic [CW-1:0]        r_rs_occ, n_rs_occ;
    logic                 r_rs_last, n_rs_last;
    logic                 r_pd_vld, n_pd_vld;
    logic                 r_pd_pass, n_pd_pass;

    logic [RQ_CW:0]       pend;
    logic                 credit;
    logic                 full, empty;
    logic [CW-1:0]        last_idx;
    logic [AW-1:0]        front_dec;
    logic signed [WORD_W-1:0] rd_word;
    logic [OCC_W-1:0]     occ_out;

    // A result may start only if the result queue will have room when it lands.
    assign pend      = (RQ_CW + 1)'(i_level) + (RQ_CW + 1)'(r_rs_vld);
    assign credit    = (pend < (RQ_CW + 1)'(RQ_DEPTH));
    assign full      = (r_count == CW'(DEPTH));
    assign empty     = (r_count == '0);
    assign last_idx  = r_count - 1'b1;
    assign front_dec = (r_front == '0) ? AW'(DEPTH - 1) : r_front - 1'b1;

    // Sequencer: next state, pointer updates and memory port control.
    always_comb begin
        n_state      = r_state;
        n_front      = r_front;
        n_count      = r_count;
        n_bank       = r_bank;
        n_idx        = r_idx;
        n_pass       = r_pass;
        n_n          = r_n;
        n_rs_vld     = 1'b0;
        n_rs_use_mem = 1'b0;
        n_rs_status  = ST_OK;
        n_rs_last    = 1'b1;
        n_pd_vld     = 1'b0;
        n_pd_pass    = r_pass;
        mem_we       = 1'b0;
        mem_waddr    = {r_bank, r_front};
        mem_wdata    = i_cmd_value;
        mem_raddr    = {r_bank, r_front};
        o_cmd_ready  = 1'b0;

        unique case (r_state)
            BK_IDLE: begin
                o_cmd_ready = credit;
                if (i_cmd_valid && credit) begin
                    n_rs_vld = 1'b1;
                    unique case (i_cmd)
                        CMD_PUSH_FRONT: begin
                            if (full) begin
                                n_rs_status = ST_FULL;
                            end else begin
                                n_front   = front_dec;
                                mem_we    = 1'b1;
                                mem_waddr = {r_bank, front_dec};
                                n_count   = r_count + 1'b1;
                            end
                        end
                        CMD_PUSH_BACK: begin
                            if (full) begin
                                n_rs_status = ST_FULL;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = {r_bank, ring_pos(r_front, r_count)};
                                n_count   = r_count + 1'b1;
                            end
                        end
                        CMD_POP_FRONT: begin
                            if (empty) begin
                                n_rs_status = ST_EMPTY;
                            end else begin
                                mem_raddr    = {r_bank, r_front};
                                n_rs_use_mem = 1'b1;
                                n_front      = ring_pos(r_front, CW'(1));
                                n_count      = r_count - 1'b1;
                            end
                        end
                        CMD_POP_BACK: begin
                            if (empty) begin
                                n_rs_status = ST_EMPTY;
                            end else begin
                                mem_raddr    = {r_bank, ring_pos(r_front, last_idx)};
                                n_rs_use_mem = 1'b1;
                                n_count      = r_count - 1'b1;
                            end
                        end
                        CMD_PARTITION: begin
                            // Fewer than two entries never change order.
                            if (r_count >= CW'(2)) begin
                                n_rs_vld = 1'b0;
                                n_state  = BK_PART;
                                n_idx    = '0;
                                n_pass   = 1'b0;
                                n_n      = '0;
                            end
                        end
                        CMD_READ_OUT: begin
                            if (empty) begin
                                n_rs_status = ST_EMPTY;
                            end else begin
                                n_rs_vld = 1'b0;
                                n_state  = BK_READ;
                                n_idx    = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            BK_READ: begin
                // One entry per cycle, front to back, as the result queue allows.
                if (credit) begin
                    mem_raddr    = {r_bank, ring_pos(r_front, r_idx)};
                    n_rs_vld     = 1'b1;
                    n_rs_use_mem = 1'b1;
                    n_rs_last    = (r_idx == last_idx);
                    n_idx        = r_idx + 1'b1;
                    if (r_idx == last_idx) begin
                        n_state = BK_IDLE;
                    end
                end
            end
            BK_PART: begin
                // Two passes over the active bank: evens first, then odds.
                mem_raddr = {r_bank, ring_pos(r_front, r_idx)};
                n_pd_vld  = 1'b1;
                n_pd_pass = r_pass;
                if (r_idx == last_idx) begin
                    n_idx = '0;
                    if (r_pass) begin
                        n_state = BK_PDRAIN;
                    end else begin
                        n_pass = 1'b1;
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            BK_PDRAIN: begin
                // Once the last read is written, swap banks and report.
                if (!r_pd_vld && credit) begin
                    n_rs_vld = 1'b1;
                    n_bank   = ~r_bank;
                    n_state  = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase

        // Partition write stage: keep words whose parity matches the pass.
        if (r_pd_vld && (r_rdata[0] == r_pd_pass)) begin
            mem_we    = 1'b1;
            mem_waddr = {~r_bank, ring_pos(r_front, r_n)};
            mem_wdata = r_rdata;
            n_n       = r_n + 1'b1;
        end

        n_rs_occ = n_count;
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BK_IDLE;
            r_front  <= '0;
            r_count  <= '0;
            r_bank   <= 1'b0;
            r_idx    <= '0;
            r_pass   <= 1'b0;
            r_n      <= '0;
            r_rs_vld <= 1'b0;
            r_pd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_front  <= n_front;
            r_count  <= n_count;
            r_bank   <= n_bank;
            r_idx    <= n_idx;
            r_pass   <= n_pass;
            r_n      <= n_n;
            r_rs_vld <= n_rs_vld;
            r_pd_vld <= n_pd_vld;
        end
    end

    // Result stage payload.
    always_ff @(posedge i_clk) begin
        r_rs_use_mem <= n_rs_use_mem;
        r_rs_status  <= n_rs_status;
        r_rs_occ     <= n_rs_occ;
        r_rs_last    <= n_rs_last;
        r_pd_pass    <= n_pd_pass;
    end

    // Entry memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    // Fit the entry and the count to the result fields.
    if (WORD_BITS >= WORD_W) begin : g_word_trunc
        assign rd_word = r_rdata[WORD_W-1:0];
    end else begin : g_word_ext
        assign rd_word = {{(WORD_W - WORD_BITS){1'b0}}, r_rdata};
    end

    if (CW >= OCC_W) begin : g_occ_trunc
        assign occ_out = r_rs_occ[OCC_W-1:0];
    end else begin : g_occ_ext
        assign occ_out = {{(OCC_W - CW){1'b0}}, r_rs_occ};
    end

    // Result word toward the output queue.
    assign o_res_push      = r_rs_vld;
    assign o_res.word      = r_rs_use_mem ? rd_word : '0;
    assign o_res.status    = r_rs_status;
    assign o_res.occupancy = occ_out;
    assign o_res.last      = r_rs_last;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("Entry count exceeds the store depth.");

    a_part_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_PDRAIN && !r_pd_vld) |-> (r_n == r_count))
        else $error("Partition did not rewrite every entry.");

    a_res_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rs_vld |-> (i_level < RQ_CW'(RQ_DEPTH)))
        else $error("Result issued without room in the result queue.");
`endif

endmodule

// File: rtl/dqp_res_q.sv
// Result queue of the deque: holds finished result words until the output side takes them.
// Depends on dqp_pkg and dqp_out_if.
module dqp_res_q (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  dqp_pkg::t_res             i_data,
    output logic [dqp_pkg::RQ_CW-1:0] o_level,
    dqp_out_if.source                 o_res
);
    import dqp_pkg::*;

    t_res             r_q [RQ_DEPTH];
    logic [RQ_AW-1:0] r_wp, r_rp;
    logic [RQ_CW-1:0] r_cnt, n_cnt;
    logic             pop;

    // Output side of the queue.
    assign o_res.valid     = (r_cnt != '0);
    assign o_res.word      = r_q[r_rp].word;
    assign o_res.status    = r_q[r_rp].status;
    assign o_res.occupancy = r_q[r_rp].occupancy;
    assign o_res.last      = r_q[r_rp].last;
    assign pop             = o_res.valid && o_res.ready;

    // Level left after this cycle's pop, used by the back end for credit.
    assign o_level = r_cnt - RQ_CW'(pop);

    always_comb begin
        case ({i_push, pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    // Pointers and level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wp  <= '0;
            r_rp  <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_data;
        end
    end

endmodule

// File: rtl/deque_with_parity_partition.sv
// Bounded deque of signed words with a stable even/odd partition. Push and pop
// commands are each handled directly from the idle state of the back end, so a
// steady stream of them runs at one word per cycle while the result queue has
// room; a pop result passes through the command queue, the memory read and the
// result queue. Read out delivers the entries front to back as the result queue
// allows. For a partition of at least two entries the back end reads the store once
// for the even words and once for the odd words through its single read port,
// writes them into the second bank of the entry memory and then swaps banks. During
// read out and partition no further command starts. The store needs no clearing after reset.
module deque_with_parity_partition #(
    parameter int DEPTH     = dqp_pkg::DEPTH_DEF,
    parameter int WORD_BITS = dqp_pkg::WORD_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dqp_in_if.sink    i_in,
    dqp_out_if.source o_res
);
    import dqp_pkg::*;

    logic                 cmd_valid;
    logic                 cmd_ready;
    t_cmd                 cmd;
    logic [WORD_BITS-1:0] cmd_value;
    logic                 res_push;
    t_res                 res;
    logic [RQ_CW-1:0]     res_level;

    // Accept and classify.
    dqp_front #(
        .WORD_BITS (WORD_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_cmd       (cmd),
        .o_cmd_value (cmd_value)
    );

    // Execute against the ring store.
    dqp_back #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd),
        .i_cmd_value (cmd_value),
        .i_level     (res_level),
        .o_res_push  (res_push),
        .o_res       (res)
    );

    // Hold results for the output side.
    dqp_res_q u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res),
        .o_level (res_level),
        .o_res   (o_res)
    );

endmodule
